// ===== rtl/pooled_ordered_task_list_core_macros.svh =====
// Assertion macros used by potl_back.
`ifndef POOLED_ORDERED_TASK_LIST_CORE_MACROS_SVH
`define POOLED_ORDERED_TASK_LIST_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define POTL_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define POTL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define POTL_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define POTL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/potl_pkg.sv =====
package potl_pkg;

    localparam int CODE_W = 8;
    localparam int IDX_W  = 3;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_ADD_BAD,
        OP_DEL,
        OP_DEL_BAD
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [CODE_W-1:0] code;
        logic [CODE_W-1:0] err;
        logic [IDX_W-1:0]  idx;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LINK,
        ST_HEAD,
        ST_DONE
    } t_state;

endpackage

// ===== rtl/potl_ram.sv =====
module potl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/potl_front.sv =====
module potl_front #(
    parameter int SLOT_COUNT = 8
) (
    input  logic                          i_valid,
    input  logic                          i_func,
    input  logic [potl_pkg::CODE_W-1:0]   i_task_code,
    input  logic [potl_pkg::CODE_W-1:0]   i_task_error,
    input  logic [potl_pkg::IDX_W-1:0]    i_slot_index,
    output logic                          o_stall,
    input  logic                          i_full,
    output logic                          o_push,
    output potl_pkg::t_cmd                o_cmd
);

    localparam int CW = potl_pkg::IDX_W + 8;

    logic in_range;

    assign in_range = CW'(i_slot_index) < CW'(SLOT_COUNT);

    always_comb begin
        o_cmd.code = i_task_code;
        o_cmd.err  = i_task_error;
        o_cmd.idx  = i_slot_index;
        if (!i_func) begin
            o_cmd.op = (i_task_code == '0) ? potl_pkg::OP_ADD_BAD : potl_pkg::OP_ADD;
        end else begin
            o_cmd.op = in_range ? potl_pkg::OP_DEL : potl_pkg::OP_DEL_BAD;
        end
    end

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

endmodule

// ===== rtl/potl_fifo.sv =====
module potl_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  potl_pkg::t_cmd i_cmd,
    output logic           o_full,
    output logic           o_valid,
    output potl_pkg::t_cmd o_cmd,
    input  logic           i_pop
);

    potl_pkg::t_cmd r_mem [2];
    logic           r_wptr;
    logic           r_rptr;
    logic [1:0]     r_count;
    logic           n_wptr;
    logic           n_rptr;
    logic [1:0]     n_count;
    logic           do_pop;

    assign o_full  = r_count == 2'd2;
    assign o_valid = r_count != 2'd0;
    assign o_cmd   = r_mem[r_rptr];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wptr  = r_wptr ^ i_push;
        n_rptr  = r_rptr ^ do_pop;
        n_count = r_count;
        if (i_push && !do_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && do_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

// ===== rtl/potl_back.sv =====
module potl_back #(
    parameter int SLOT_COUNT = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  potl_pkg::t_cmd                i_q_cmd,
    output logic                          o_q_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_done_ok,
    output logic [potl_pkg::IDX_W-1:0]    o_slot_used,
    output logic                          o_head_valid,
    output logic [potl_pkg::IDX_W-1:0]    o_head_slot,
    output logic [potl_pkg::CODE_W-1:0]   o_head_code,
    output logic [potl_pkg::CODE_W-1:0]   o_head_error
);

    `include "pooled_ordered_task_list_core_macros.svh"

    localparam int IW = $clog2(SLOT_COUNT);
    localparam int EW = 2 * potl_pkg::CODE_W;

    potl_pkg::t_state r_state, n_state;
    potl_pkg::t_cmd   r_cmd, n_cmd;

    logic [SLOT_COUNT-1:0]        r_busy, n_busy;
    logic                         r_head_vld, n_head_vld;
    logic [IW-1:0]                r_head, n_head;
    logic [IW-1:0]                r_tail, n_tail;
    logic [potl_pkg::CODE_W-1:0]  r_head_code, n_head_code;
    logic [potl_pkg::CODE_W-1:0]  r_head_err, n_head_err;
    logic                         r_ok, n_ok;
    logic [potl_pkg::IDX_W-1:0]   r_used, n_used;

    logic                         r_out_vld, n_out_vld;
    logic                         r_out_ok;
    logic [potl_pkg::IDX_W-1:0]   r_out_used;
    logic                         r_out_hvld;
    logic [potl_pkg::IDX_W-1:0]   r_out_hslot;
    logic [potl_pkg::CODE_W-1:0]  r_out_hcode;
    logic [potl_pkg::CODE_W-1:0]  r_out_herr;
    logic                         out_free;

    logic [IW-1:0] free_idx;
    logic          free_any;
    logic [IW-1:0] q_slot;
    logic [IW-1:0] c_slot;
    logic          nx_vld;

    logic          ent_we;
    logic [IW-1:0] ent_waddr;
    logic [EW-1:0] ent_wdata;
    logic [EW-1:0] ent_rdata;
    logic          nxt_we;
    logic [IW-1:0] nxt_waddr;
    logic [IW-1:0] nxt_wdata;
    logic [IW-1:0] nxt_rdata;
    logic          prv_we;
    logic [IW-1:0] prv_waddr;
    logic [IW-1:0] prv_wdata;
    logic [IW-1:0] prv_rdata;

    potl_ram #(.WIDTH(EW), .DEPTH(SLOT_COUNT)) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_raddr (nxt_rdata),
        .o_rdata (ent_rdata)
    );

    potl_ram #(.WIDTH(IW), .DEPTH(SLOT_COUNT)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (nxt_we),
        .i_waddr (nxt_waddr),
        .i_wdata (nxt_wdata),
        .i_raddr (q_slot),
        .o_rdata (nxt_rdata)
    );

    potl_ram #(.WIDTH(IW), .DEPTH(SLOT_COUNT)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (prv_we),
        .i_waddr (prv_waddr),
        .i_wdata (prv_wdata),
        .i_raddr (q_slot),
        .o_rdata (prv_rdata)
    );

    assign q_slot   = IW'(i_q_cmd.idx);
    assign c_slot   = IW'(r_cmd.idx);
    assign nx_vld   = c_slot != r_tail;
    assign out_free = !r_out_vld || !i_out_stall;
    assign free_any = ~&r_busy;

    always_comb begin
        free_idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!r_busy[i]) begin
                free_idx = IW'(i);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            potl_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_cmd.op == potl_pkg::OP_DEL && r_busy[q_slot]) begin
                        n_state = potl_pkg::ST_LINK;
                    end else begin
                        n_state = potl_pkg::ST_DONE;
                    end
                end
            end
            potl_pkg::ST_LINK: begin
                if (c_slot == r_head && nx_vld) begin
                    n_state = potl_pkg::ST_HEAD;
                end else begin
                    n_state = potl_pkg::ST_DONE;
                end
            end
            potl_pkg::ST_HEAD: begin
                n_state = potl_pkg::ST_DONE;
            end
            potl_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = potl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = potl_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_cmd       = r_cmd;
        n_busy      = r_busy;
        n_head_vld  = r_head_vld;
        n_head      = r_head;
        n_tail      = r_tail;
        n_head_code = r_head_code;
        n_head_err  = r_head_err;
        n_ok        = r_ok;
        n_used      = r_used;
        n_out_vld   = r_out_vld && i_out_stall;
        o_q_pop     = 1'b0;
        ent_we      = 1'b0;
        ent_waddr   = free_idx;
        ent_wdata   = {i_q_cmd.code, i_q_cmd.err};
        nxt_we      = 1'b0;
        nxt_waddr   = r_tail;
        nxt_wdata   = free_idx;
        prv_we      = 1'b0;
        prv_waddr   = free_idx;
        prv_wdata   = r_tail;
        case (r_state)
            potl_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_cmd;
                    n_ok    = 1'b0;
                    n_used  = '0;
                    case (i_q_cmd.op)
                        potl_pkg::OP_ADD: begin
                            if (free_any) begin
                                ent_we           = 1'b1;
                                n_busy[free_idx] = 1'b1;
                                n_tail           = free_idx;
                                n_ok             = 1'b1;
                                n_used           = potl_pkg::IDX_W'(free_idx);
                                if (r_head_vld) begin
                                    nxt_we = 1'b1;
                                    prv_we = 1'b1;
                                end else begin
                                    n_head_vld  = 1'b1;
                                    n_head      = free_idx;
                                    n_head_code = i_q_cmd.code;
                                    n_head_err  = i_q_cmd.err;
                                end
                            end
                        end
                        potl_pkg::OP_DEL, potl_pkg::OP_DEL_BAD: begin
                            n_used = i_q_cmd.idx;
                        end
                        default: begin
                            n_used = '0;
                        end
                    endcase
                end
            end
            potl_pkg::ST_LINK: begin
                n_busy[c_slot] = 1'b0;
                n_ok           = 1'b1;
                if (c_slot == r_head) begin
                    if (nx_vld) begin
                        n_head = nxt_rdata;
                    end else begin
                        n_head_vld  = 1'b0;
                        n_head_code = '0;
                        n_head_err  = '0;
                    end
                end else if (nx_vld) begin
                    nxt_we    = 1'b1;
                    nxt_waddr = prv_rdata;
                    nxt_wdata = nxt_rdata;
                    prv_we    = 1'b1;
                    prv_waddr = nxt_rdata;
                    prv_wdata = prv_rdata;
                end else begin
                    n_tail = prv_rdata;
                end
            end
            potl_pkg::ST_HEAD: begin
                {n_head_code, n_head_err} = ent_rdata;
            end
            potl_pkg::ST_DONE: begin
                if (out_free) begin
                    n_out_vld = 1'b1;
                end
            end
            default: begin
                n_cmd = r_cmd;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= potl_pkg::ST_IDLE;
            r_busy     <= '0;
            r_head_vld <= 1'b0;
            r_head     <= '0;
            r_tail     <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_busy     <= n_busy;
            r_head_vld <= n_head_vld;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_head_code <= n_head_code;
        r_head_err  <= n_head_err;
        r_ok        <= n_ok;
        r_used      <= n_used;
        if (r_state == potl_pkg::ST_DONE && out_free) begin
            r_out_ok    <= r_ok;
            r_out_used  <= r_used;
            r_out_hvld  <= r_head_vld;
            r_out_hslot <= r_head_vld ? potl_pkg::IDX_W'(r_head) : '0;
            r_out_hcode <= r_head_vld ? r_head_code : '0;
            r_out_herr  <= r_head_vld ? r_head_err : '0;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_done_ok    = r_out_ok;
    assign o_slot_used  = r_out_used;
    assign o_head_valid = r_out_hvld;
    assign o_head_slot  = r_out_hslot;
    assign o_head_code  = r_out_hcode;
    assign o_head_error = r_out_herr;

    `POTL_ASSERT_IMPLY(a_head_busy, i_clk, i_rst_n, r_head_vld, r_busy[r_head])
    `POTL_ASSERT_IMPLY(a_tail_busy, i_clk, i_rst_n, r_head_vld, r_busy[r_tail])
    `POTL_ASSERT_IMPLY(a_empty_free, i_clk, i_rst_n, !r_head_vld, r_busy == '0)
    `POTL_ASSERT_NEXT(a_done_emits, i_clk, i_rst_n, r_state == potl_pkg::ST_DONE && out_free, r_out_vld)

endmodule

// ===== rtl/pooled_ordered_task_list_core.sv =====
// Ordered task list over a pool of SLOT_COUNT slots.
// Input channel (i_in_valid / o_in_stall): one transaction is an add
// (i_func 0, code and error byte) or a delete of the slot i_slot_index.
// Output channel (o_out_valid / i_out_stall): one result per transaction,
// with the pass flag, the slot used and the head of the list after it.
// Accepted transactions wait in a two-entry queue in front of the list
// sequencer, so input keeps flowing while a result waits on a stall.
// From the queue, adds and rejected commands go from the idle state
// straight to the done state; a delete of a linked slot passes through
// the link state, and a delete of a head with a successor also through
// the head state, which loads the new head's code and error byte.
// The sequencer finishes one transaction before it pops the next from
// the queue; the registered reads of the link memories set its steps.
// A stalled result holds in the output register; the sequencer waits with
// the next result and the queue fills, then o_in_stall rises.
// Synchronous reset empties the list through the slot busy
// bits; the slot memories need no clearing pass.
module pooled_ordered_task_list_core #(
    parameter int SLOT_COUNT = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_func,
    input  logic [potl_pkg::CODE_W-1:0]   i_task_code,
    input  logic [potl_pkg::CODE_W-1:0]   i_task_error,
    input  logic [potl_pkg::IDX_W-1:0]    i_slot_index,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_done_ok,
    output logic [potl_pkg::IDX_W-1:0]    o_slot_used,
    output logic                          o_head_valid,
    output logic [potl_pkg::IDX_W-1:0]    o_head_slot,
    output logic [potl_pkg::CODE_W-1:0]   o_head_code,
    output logic [potl_pkg::CODE_W-1:0]   o_head_error
);

    logic           q_full;
    logic           q_push;
    potl_pkg::t_cmd f_cmd;
    logic           q_valid;
    potl_pkg::t_cmd q_cmd;
    logic           q_pop;

    potl_front #(.SLOT_COUNT(SLOT_COUNT)) u_front (
        .i_valid      (i_in_valid),
        .i_func       (i_func),
        .i_task_code  (i_task_code),
        .i_task_error (i_task_error),
        .i_slot_index (i_slot_index),
        .o_stall      (o_in_stall),
        .i_full       (q_full),
        .o_push       (q_push),
        .o_cmd        (f_cmd)
    );

    potl_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    potl_back #(.SLOT_COUNT(SLOT_COUNT)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_cmd      (q_cmd),
        .o_q_pop      (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_done_ok    (o_done_ok),
        .o_slot_used  (o_slot_used),
        .o_head_valid (o_head_valid),
        .o_head_slot  (o_head_slot),
        .o_head_code  (o_head_code),
        .o_head_error (o_head_error)
    );

endmodule

// ===== dv/pooled_ordered_task_list_core_tb.sv =====
module pooled_ordered_task_list_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import potl_pkg::*;

    localparam int          SLOTS      = 8;
    localparam logic [3:0]  NULL_LINK  = 4'd8;
    localparam logic        FUNC_ADD   = 1'b0;
    localparam logic        FUNC_DEL   = 1'b1;
    localparam int          RAND_ITEMS = 1200;
    localparam int          IDLE_LIMIT = 1000;
    localparam int          DRAIN_WAIT = 10;

    typedef struct packed {
        logic              func;
        logic [CODE_W-1:0] code;
        logic [CODE_W-1:0] err;
        logic [IDX_W-1:0]  idx;
    } task_cmd_t;

    typedef struct packed {
        logic              done_ok;
        logic [IDX_W-1:0]  slot_used;
        logic              head_valid;
        logic [IDX_W-1:0]  head_slot;
        logic [CODE_W-1:0] head_code;
        logic [CODE_W-1:0] head_error;
    } list_status_t;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_in_valid   = 1'b0;
    logic              o_in_stall;
    logic              i_func       = FUNC_ADD;
    logic [CODE_W-1:0] i_task_code  = '0;
    logic [CODE_W-1:0] i_task_error = '0;
    logic [IDX_W-1:0]  i_slot_index = '0;
    logic              o_out_valid;
    logic              i_out_stall  = 1'b0;
    logic              o_done_ok;
    logic [IDX_W-1:0]  o_slot_used;
    logic              o_head_valid;
    logic [IDX_W-1:0]  o_head_slot;
    logic [CODE_W-1:0] o_head_code;
    logic [CODE_W-1:0] o_head_error;

    pooled_ordered_task_list_core #(
        .SLOT_COUNT(SLOTS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_func      (i_func),
        .i_task_code (i_task_code),
        .i_task_error(i_task_error),
        .i_slot_index(i_slot_index),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_done_ok   (o_done_ok),
        .o_slot_used (o_slot_used),
        .o_head_valid(o_head_valid),
        .o_head_slot (o_head_slot),
        .o_head_code (o_head_code),
        .o_head_error(o_head_error)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    logic [CODE_W-1:0] task_code_mem [SLOTS];
    logic [CODE_W-1:0] task_err_mem  [SLOTS];
    logic [3:0]        fwd_link      [SLOTS];
    logic [3:0]        back_link     [SLOTS];
    logic [3:0]        list_head     = NULL_LINK;

    task_cmd_t    pending_cmds[$];
    list_status_t status_due[$];
    task_cmd_t    on_bus;
    int           cmds_total    = 0;
    int           cmds_accepted = 0;
    int           mismatch_count = 0;
    int           burst_left    = 0;
    int           gap_left      = 0;
    int           stall_mode    = 0;
    int           stall_cycle   = 0;
    int           idle_cycles   = 0;

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            task_code_mem[i] = '0;
            task_err_mem[i]  = '0;
            fwd_link[i]      = NULL_LINK;
            back_link[i]     = NULL_LINK;
        end
    end

    function automatic list_status_t run_list_cmd(task_cmd_t c);
        list_status_t r;
        logic [3:0]   cur;
        logic [3:0]   nx;
        logic [3:0]   pv;
        logic [3:0]   s;
        logic         unlinked;
        r        = '0;
        unlinked = 1'b0;
        if (c.func == FUNC_ADD) begin
            if (c.code != '0) begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (!r.done_ok && task_code_mem[i] == '0) begin
                        task_code_mem[i] = c.code;
                        task_err_mem[i]  = c.err;
                        fwd_link[i]      = NULL_LINK;
                        if (list_head >= SLOTS) begin
                            list_head    = 4'(i);
                            back_link[i] = NULL_LINK;
                        end else begin
                            cur = list_head;
                            for (int n = 0; n < SLOTS; n++) begin
                                if (fwd_link[cur] >= SLOTS) break;
                                cur = fwd_link[cur];
                            end
                            fwd_link[cur] = 4'(i);
                            back_link[i]  = cur;
                        end
                        r.done_ok   = 1'b1;
                        r.slot_used = IDX_W'(i);
                    end
                end
            end
        end else begin
            s                = {1'b0, c.idx};
            r.slot_used      = c.idx;
            task_code_mem[s] = '0;
            task_err_mem[s]  = '0;
            nx               = fwd_link[s];
            pv               = back_link[s];
            if (list_head == s) begin
                list_head = nx;
                if (nx < SLOTS) back_link[nx] = NULL_LINK;
                unlinked = 1'b1;
            end else if (pv < SLOTS) begin
                fwd_link[pv] = nx;
                if (nx < SLOTS) back_link[nx] = pv;
                unlinked = 1'b1;
            end
            if (unlinked) begin
                fwd_link[s]  = NULL_LINK;
                back_link[s] = NULL_LINK;
                r.done_ok    = 1'b1;
            end
        end
        if (list_head < SLOTS) begin
            r.head_valid = 1'b1;
            r.head_slot  = list_head[IDX_W-1:0];
            r.head_code  = task_code_mem[list_head];
            r.head_error = task_err_mem[list_head];
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $realtime, field, got, want);
        mismatch_count++;
    endtask

    function automatic void queue_cmd(logic func, int code, int err, int idx);
        task_cmd_t c;
        c.func = func;
        c.code = CODE_W'(code);
        c.err  = CODE_W'(err);
        c.idx  = IDX_W'(idx);
        pending_cmds.push_back(c);
        cmds_total++;
    endfunction

    // Driver: bursts of transactions separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                status_due.push_back(run_list_cmd(on_bus));
                cmds_accepted++;
            end
            if (!(i_in_valid && o_in_stall)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    on_bus = pending_cmds.pop_front();
                    i_func       <= on_bus.func;
                    i_task_code  <= on_bus.code;
                    i_task_error <= on_bus.err;
                    i_slot_index <= on_bus.idx;
                    i_in_valid   <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 30);
                        gap_left   = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor and receiver stall pattern.
    always @(posedge i_clk) begin
        list_status_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (status_due.size() == 0) begin
                report_mismatch("unexpected transaction", o_done_ok, 0);
            end else begin
                want = status_due.pop_front();
                if (o_done_ok !== want.done_ok)
                    report_mismatch("done_ok", o_done_ok, want.done_ok);
                if (o_slot_used !== want.slot_used)
                    report_mismatch("slot_used", o_slot_used, want.slot_used);
                if (o_head_valid !== want.head_valid)
                    report_mismatch("head_valid", o_head_valid, want.head_valid);
                if (o_head_slot !== want.head_slot)
                    report_mismatch("head_slot", o_head_slot, want.head_slot);
                if (o_head_code !== want.head_code)
                    report_mismatch("head_code", o_head_code, want.head_code);
                if (o_head_error !== want.head_error)
                    report_mismatch("head_error", o_head_error, want.head_error);
            end
        end
        stall_cycle++;
        if (stall_cycle % 64 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            1: i_out_stall <= ($urandom_range(0, 99) < 30);
            2: i_out_stall <= ($urandom_range(0, 99) < 70);
            3: i_out_stall <= (stall_cycle % 4 != 0);
            default: i_out_stall <= 1'b0;
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $realtime, IDLE_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        int add_pct;
        // Empty list: zero code, unlinked delete.
        queue_cmd(FUNC_ADD, 8'h00, 8'hFF, 7);
        queue_cmd(FUNC_DEL, 8'hFF, 8'hFF, 3);
        // Fill the pool, then overflow it.
        queue_cmd(FUNC_ADD, 8'h01, 8'h00, 0);
        queue_cmd(FUNC_ADD, 8'hFF, 8'hFF, 7);
        queue_cmd(FUNC_ADD, 8'h80, 8'h7F, 5);
        queue_cmd(FUNC_ADD, 8'h7F, 8'h80, 2);
        queue_cmd(FUNC_ADD, 8'h55, 8'hAA, 1);
        queue_cmd(FUNC_ADD, 8'hAA, 8'h55, 6);
        queue_cmd(FUNC_ADD, 8'h0F, 8'hF0, 3);
        queue_cmd(FUNC_ADD, 8'hF0, 8'h0F, 4);
        queue_cmd(FUNC_ADD, 8'h42, 8'h24, 0);
        // Head, middle, tail, then a slot already unlinked.
        queue_cmd(FUNC_DEL, 8'h00, 8'h00, 0);
        queue_cmd(FUNC_DEL, 8'h00, 8'h00, 4);
        queue_cmd(FUNC_DEL, 8'h00, 8'h00, 7);
        queue_cmd(FUNC_DEL, 8'h00, 8'h00, 4);
        queue_cmd(FUNC_ADD, 8'h33, 8'hCC, 5);
        queue_cmd(FUNC_ADD, 8'h00, 8'h11, 2);
        // Drain to empty through the head.
        queue_cmd(FUNC_DEL, 8'h00, 8'h00, 1);
        queue_cmd(FUNC_DEL, 8'h00, 8'h00, 2);
        queue_cmd(FUNC_DEL, 8'h00, 8'h00, 3);
        queue_cmd(FUNC_DEL, 8'h00, 8'h00, 5);
        queue_cmd(FUNC_DEL, 8'h00, 8'h00, 6);
        queue_cmd(FUNC_DEL, 8'h00, 8'h00, 0);
        queue_cmd(FUNC_ADD, 8'hFE, 8'h01, 7);
        queue_cmd(FUNC_DEL, 8'h01, 8'hFE, 0);
        // Random phases that lean toward filling or draining the pool, or hold it balanced.
        for (int seg = 0; seg < RAND_ITEMS / 40; seg++) begin
            case ($urandom_range(0, 2))
                0: add_pct = 15;
                1: add_pct = 50;
                default: add_pct = 85;
            endcase
            for (int n = 0; n < 40; n++) begin
                queue_cmd(($urandom_range(0, 99) < add_pct) ? FUNC_ADD : FUNC_DEL,
                          ($urandom_range(0, 24) == 0) ? 0 : $urandom_range(1, 255),
                          $urandom_range(0, 255), $urandom_range(0, 7));
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmds_accepted < cmds_total || status_due.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
